// ----- rtl/core/imvrs_pkg.sv -----
// Shared types and constants of the int8-weight matrix-vector engine.
// Used by the activation store and by the engine top level; no dependencies.
package imvrs_pkg;

    localparam int MAX_INPUTS = 1024;
    localparam int LANES      = 4;

    localparam int COL_W      = $clog2(MAX_INPUTS);
    localparam int LEN_W      = COL_W + 1;
    localparam int LANE_AW    = $clog2(LANES);
    localparam int STORE_ROWS = MAX_INPUTS / LANES;
    localparam int ROW_AW     = $clog2(STORE_ROWS);

    localparam int ACT_W      = 16;
    localparam int WGT_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = ACT_W + WGT_W;
    localparam int DOT_W      = PROD_W + LANE_AW;
    localparam int ACC_W      = 40;
    localparam int MUL_W      = ACC_W + SCALE_W;
    localparam int FRAC_SHIFT = 14;
    localparam int RES_W      = 32;
    localparam int SHIFTED_W  = MUL_W - FRAC_SHIFT;
    localparam int ROWCNT_W   = 16;
    localparam int CFG_W      = 16;

    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    typedef logic signed [ACT_W-1:0] act_t;
    typedef act_t [LANES-1:0] act_row_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
        logic [LANE_AW-1:0] lane;
        act_t              data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
    } store_rd_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_SCALE = 4'b0100,
        S_ROUND = 4'b1000
    } state_t;

endpackage

// ----- rtl/core/imvrs_store.sv -----
// Activation store: one synchronous memory, one row of LANES activations per word.
// Lane-wide writes, registered full-row reads. Depends on imvrs_pkg.
module imvrs_store (
    input  logic                  clk,
    input  imvrs_pkg::store_wr_t  wr,
    input  imvrs_pkg::store_rd_t  rd,
    output imvrs_pkg::act_row_t   rd_data
);
    import imvrs_pkg::*;

    act_row_t act_mem [STORE_ROWS];
    act_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            act_mem[wr.row][wr.lane] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= act_mem[rd.row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/int8_weight_matvec_row_scaled.sv -----
// Int8-weight matrix-vector engine with a Q1.14 scale per output row.
// Usage:
//   Input channel (in_valid/in_ready): a beat with action 0 writes one Q3.12
//   activation at index; a beat with action 1 carries four int8 weights for the
//   next four columns of the current row and that row's scale.
//   Output channel (out_valid/out_ready): one beat per finished row with the
//   rounded, saturated Q.12 result, the row number and the last-row flag.
//   Configuration: cfg_we writes cfg_data into row_length or row_count.
// Timing: an activation write leaves the engine idle. A weight beat runs the
//   store read of a full four-column row, then the four multiplies and the
//   accumulate. After the beat that ends a row, the 40x16 scale multiply
//   and the round/saturate stage follow, and the result is registered into
//   the output register once that register is free.
// Reset clears the accumulator, column and row counters and restores
//   row_length 16 and row_count 1; the activation store is not cleared and
//   every entry must be written before a weight beat uses it.
// A stalled receiver holds the result in the output register; the engine keeps
//   taking beats and only waits when a second row result is ready.
module int8_weight_matvec_row_scaled (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [imvrs_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [9:0]                        index,
    input  logic signed [15:0]                activation,
    input  logic signed [7:0]                 weight_lane0,
    input  logic signed [7:0]                 weight_lane1,
    input  logic signed [7:0]                 weight_lane2,
    input  logic signed [7:0]                 weight_lane3,
    input  logic signed [15:0]                row_scale,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                result,
    output logic                              saturated,
    output logic [15:0]                       row_number,
    output logic                              last_row
);
    import imvrs_pkg::*;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]    row_length_reg;
    logic [ROWCNT_W-1:0] row_count_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROWCNT_W-1:0] row_ctr_reg, row_ctr_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [WGT_W-1:0]   weight_reg [LANES];
    logic signed [SCALE_W-1:0] scale_reg;
    logic signed [MUL_W-1:0]   mul_reg;
    logic signed [RES_W-1:0]   result_reg;
    logic                      saturated_reg;
    logic [ROWCNT_W-1:0]       row_number_reg;
    logic                      last_row_reg;

    store_wr_t store_wr;
    store_rd_t store_rd;
    act_row_t  act_row;

    logic                    in_accept;
    logic [LEN_W-1:0]        len_eff;
    logic [ROWCNT_W-1:0]     cnt_eff;
    logic [LEN_W-1:0]        col_ext;
    logic                    row_end;
    logic signed [PROD_W-1:0] lane_prod [LANES];
    logic signed [DOT_W-1:0] dot_sum;
    logic signed [MUL_W-1:0] rounded_sum;
    logic [SHIFTED_W-1:0]    shifted;
    logic                    sat_hi, sat_lo;
    logic                    out_free;
    logic                    is_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Register semantics: zero length means one column, anything above the store size clamps.
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (row_length_reg > LEN_W'(MAX_INPUTS))
        begin
            len_eff = LEN_W'(MAX_INPUTS);
        end
        else
        begin
            len_eff = row_length_reg;
        end
    end

    assign cnt_eff = (row_count_reg == '0) ? ROWCNT_W'(1) : row_count_reg;
    assign is_last = (row_ctr_reg >= cnt_eff - ROWCNT_W'(1));

    assign store_wr.en   = in_accept && (action == ACT_LOAD);
    assign store_wr.row  = index[COL_W-1:LANE_AW];
    assign store_wr.lane = index[LANE_AW-1:0];
    assign store_wr.data = activation;

    // The column position is always a multiple of the lane count, so one row read covers a beat.
    assign store_rd.en  = in_accept && (action == ACT_WEIGHT);
    assign store_rd.row = col_reg[COL_W-1:LANE_AW];

    imvrs_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (act_row)
    );

    assign col_ext = {1'b0, col_reg};
    assign row_end = (col_ext + LEN_W'(LANES)) >= len_eff;

    always_comb
    begin
        dot_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_prod[i] = weight_reg[i] * act_row[i];
            if ((col_ext + LEN_W'(i)) < len_eff)
            begin
                dot_sum = dot_sum + DOT_W'(lane_prod[i]);
            end
        end
    end

    assign rounded_sum = mul_reg + MUL_W'(1 << (FRAC_SHIFT - 1));
    assign shifted     = rounded_sum[MUL_W-1:FRAC_SHIFT];
    assign sat_hi      = !shifted[SHIFTED_W-1] && (|shifted[SHIFTED_W-2:RES_W-1]);
    assign sat_lo      = shifted[SHIFTED_W-1] && !(&shifted[SHIFTED_W-2:RES_W-1]);

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_ctr_next   = row_ctr_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action == ACT_WEIGHT))
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                acc_next = acc_reg + ACC_W'(dot_sum);
                if (row_end)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    col_next   = col_reg + COL_W'(LANES);
                    state_next = S_IDLE;
                end
            end
            S_SCALE:
            begin
                acc_next   = '0;
                col_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    row_ctr_next   = is_last ? '0 : row_ctr_reg + ROWCNT_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= '0;
            row_ctr_reg    <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            row_length_reg <= LEN_W'(16);
            row_count_reg  <= ROWCNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_ctr_reg   <= row_ctr_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_LENGTH: row_length_reg <= cfg_data[LEN_W-1:0];
                    CFG_ROW_COUNT:  row_count_reg  <= cfg_data[ROWCNT_W-1:0];
                    default:        row_count_reg  <= row_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (action == ACT_WEIGHT))
        begin
            weight_reg[0] <= weight_lane0;
            weight_reg[1] <= weight_lane1;
            weight_reg[2] <= weight_lane2;
            weight_reg[3] <= weight_lane3;
            scale_reg     <= row_scale;
        end
        if (state_reg == S_SCALE)
        begin
            mul_reg <= $signed(acc_reg) * scale_reg;
        end
        if ((state_reg == S_ROUND) && out_free)
        begin
            if (sat_hi)
            begin
                result_reg <= {1'b0, {(RES_W-1){1'b1}}};
            end
            else if (sat_lo)
            begin
                result_reg <= {1'b1, {(RES_W-1){1'b0}}};
            end
            else
            begin
                result_reg <= shifted[RES_W-1:0];
            end
            saturated_reg  <= sat_hi || sat_lo;
            row_number_reg <= row_ctr_reg;
            last_row_reg   <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result     = result_reg;
    assign saturated  = saturated_reg;
    assign row_number = row_number_reg;
    assign last_row   = last_row_reg;

    a_weight_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_WEIGHT) |=> state_reg == S_MAC)
        else $error("weight beat did not start the accumulate step");

    a_col_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg[LANE_AW-1:0] == '0)
        else $error("column position lost lane alignment");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            result == 32'sh7fffffff || result == 32'sh80000000)
        else $error("saturated flag set on an unclipped result");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && out_free && is_last |=> row_ctr_reg == '0)
        else $error("row counter did not wrap after the last row");

    a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCALE |=> acc_reg == '0 && col_reg == '0)
        else $error("row state not cleared after the row end");

endmodule
